[sv/rgb_to_ycbcr_subsample_core_defines.svh]
// Assertion macros for the RGB to YCbCr subsampling core.
// Included by the top level; no other dependencies.
`ifndef RGB_TO_YCBCR_SUBSAMPLE_CORE_DEFINES_SVH
`define RGB_TO_YCBCR_SUBSAMPLE_CORE_DEFINES_SVH

`ifndef SYNTH
`define RYCS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RYCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RYCS_ASSERT(lbl, clk, rst, prop, msg)
`define RYCS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[sv/rycs_pkg.sv]
// Shared constants, types and helpers of the RGB to YCbCr subsampling core.
// No dependencies; used by rycs_csc and rgb_to_ycbcr_subsample_core.
`timescale 1ns / 1ps
`default_nettype none

package rycs_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned BYTE_MAX = 255;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned COEF_W   = 16;
   localparam int unsigned PROD_W   = 24;
   localparam int unsigned ACC_W    = 26;

   localparam logic [COEF_W-1:0] KY_R = 16'd16829;
   localparam logic [COEF_W-1:0] KY_G = 16'd33039;
   localparam logic [COEF_W-1:0] KY_B = 16'd6416;
   localparam logic [COEF_W-1:0] KB_R = 16'd9714;
   localparam logic [COEF_W-1:0] KB_G = 16'd19070;
   localparam logic [COEF_W-1:0] KB_B = 16'd28784;
   localparam logic [COEF_W-1:0] KR_R = 16'd28784;
   localparam logic [COEF_W-1:0] KR_G = 16'd24103;
   localparam logic [COEF_W-1:0] KR_B = 16'd4681;

   localparam logic [ACC_W-1:0] Y_OFFSET = ACC_W'(16 << FRAC_W);
   localparam logic [ACC_W-1:0] C_OFFSET = ACC_W'(128 << FRAC_W);

   localparam int unsigned LINE_WIDTH_W = 11;
   localparam int unsigned BLOCK_SIZE_W = 4;
   localparam int unsigned CSR_DATA_W   = 11;
   localparam int unsigned CSR_INDEX_W  = 1;
   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 11'd640;
   localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RST = 4'd2;

   localparam int unsigned DEF_MAX_WIDTH = 1024;
   localparam int unsigned DEF_MAX_BLOCK = 8;

   localparam int unsigned REQ_DATA_W = 3 * BYTE_W;
   localparam int unsigned RSP_DATA_W = 3 * BYTE_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_WIDTH = CSR_INDEX_W'(0),
      CSR_BLOCK_SIZE = CSR_INDEX_W'(1)
   } csr_reg_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } rycs_adv_type;

   // drop fraction, clamp to a byte
   function automatic logic [BYTE_W-1:0] q16_to_byte(input logic [ACC_W-1:0] v);
      logic [ACC_W-FRAC_W-1:0] whole;
      whole = v[ACC_W-1:FRAC_W];
      if (v[ACC_W-1]) begin
         return '0;
      end
      if (whole > (ACC_W-FRAC_W)'(BYTE_MAX)) begin
         return BYTE_W'(BYTE_MAX);
      end
      return whole[BYTE_W-1:0];
   endfunction

endpackage

`default_nettype wire

[sv/rycs_csc.sv]
// Three-stage BT.601 color matrix: pixel register, products, offset sum and clamp.
// Depends on rycs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rycs_csc (
   input  logic                            clock,
   input  rycs_pkg::rycs_adv_type          adv,
   input  logic [rycs_pkg::BYTE_W-1:0]     red,
   input  logic [rycs_pkg::BYTE_W-1:0]     green,
   input  logic [rycs_pkg::BYTE_W-1:0]     blue,
   output logic [rycs_pkg::BYTE_W-1:0]     luma,
   output logic [rycs_pkg::BYTE_W-1:0]     cb,
   output logic [rycs_pkg::BYTE_W-1:0]     cr
);
   import rycs_pkg::*;

   logic [BYTE_W-1:0] r_ff, g_ff, b_ff;
   logic [PROD_W-1:0] yr_ff, yg_ff, yb_ff;
   logic [PROD_W-1:0] br_ff, bg_ff, bb_ff;
   logic [PROD_W-1:0] rr_ff, rg_ff, rb_ff;
   logic [BYTE_W-1:0] y_ff, cb_ff, cr_ff;
   logic [ACC_W-1:0]  y_acc, cb_acc, cr_acc;

   always_comb begin
      y_acc  = Y_OFFSET + ACC_W'(yr_ff) + ACC_W'(yg_ff) + ACC_W'(yb_ff);
      cb_acc = C_OFFSET - ACC_W'(br_ff) - ACC_W'(bg_ff) + ACC_W'(bb_ff);
      cr_acc = C_OFFSET + ACC_W'(rr_ff) - ACC_W'(rg_ff) - ACC_W'(rb_ff);
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         r_ff <= red;
         g_ff <= green;
         b_ff <= blue;
      end
      if (adv.s2) begin
         yr_ff <= PROD_W'(r_ff) * PROD_W'(KY_R);
         yg_ff <= PROD_W'(g_ff) * PROD_W'(KY_G);
         yb_ff <= PROD_W'(b_ff) * PROD_W'(KY_B);
         br_ff <= PROD_W'(r_ff) * PROD_W'(KB_R);
         bg_ff <= PROD_W'(g_ff) * PROD_W'(KB_G);
         bb_ff <= PROD_W'(b_ff) * PROD_W'(KB_B);
         rr_ff <= PROD_W'(r_ff) * PROD_W'(KR_R);
         rg_ff <= PROD_W'(g_ff) * PROD_W'(KR_G);
         rb_ff <= PROD_W'(b_ff) * PROD_W'(KR_B);
      end
      if (adv.s3) begin
         y_ff  <= q16_to_byte(y_acc);
         cb_ff <= q16_to_byte(cb_acc);
         cr_ff <= q16_to_byte(cr_acc);
      end
   end

   assign luma = y_ff;
   assign cb   = cb_ff;
   assign cr   = cr_ff;

endmodule

`default_nettype wire

[sv/rgb_to_ycbcr_subsample_core.sv]
// Top level of the RGB to YCbCr converter with square-block chroma averaging.
// Depends on rycs_pkg, rycs_csc and rgb_to_ycbcr_subsample_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_ycbcr_subsample_core_defines.svh"

// Takes one pixel per clock and gives one result per pixel through seven pipeline
// registers; a stall on the result side backs up through the stages and lowers
// req_tready only when every stage is full. Per-block-column chroma sums live in
// one single-port-read, single-port-write memory of MAX_WIDTH entries; the
// read-modify-write reads as an item enters stage 4 and writes back as it enters
// stage 5; a same-entry write is forwarded to the following read, so the memory
// port sets the rate at one pixel per clock.
// Column and block divisions use reciprocal tables with a one-step correction.
// The memory is not cleared after reset: the first pixel of each block seeds
// its entry, so only a register change in mid-block can expose stale sums.
// Registers may be written only while no item is in flight.
module rgb_to_ycbcr_subsample_core #(
   parameter int unsigned MAX_WIDTH = rycs_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_BLOCK = rycs_pkg::DEF_MAX_BLOCK
) (
   input  logic                               clock,
   input  logic                               reset,
   // red[7:0], green[15:8], blue[23:16]
   input  logic [rycs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // frame_start
   input  logic                               req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // luma[7:0], blue_diff[15:8], red_diff[23:16]
   output logic [rycs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // chroma_valid
   output logic                               rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [rycs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rycs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rycs_pkg::*;

   localparam int unsigned STAGES = 7;
   localparam int unsigned POS_W  = $clog2(MAX_WIDTH);
   localparam int unsigned WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int unsigned BS_W   = $clog2(MAX_BLOCK + 1);
   localparam int unsigned ROW_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam int unsigned SUM_W  = BYTE_W + 2 * $clog2(MAX_BLOCK);
   localparam int unsigned AREA_W = 2 * BS_W;

   // configuration
   logic [LINE_WIDTH_W-1:0] lw_ff, lw_in;
   logic [BLOCK_SIZE_W-1:0] bs_ff, bs_in;
   logic [WID_W-1:0]        w_eff;
   logic [BS_W-1:0]         bs_eff;
   logic [AREA_W-1:0]       area;

   always_comb begin
      lw_in = lw_ff;
      bs_in = bs_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            CSR_LINE_WIDTH: lw_in = csr_wdata[LINE_WIDTH_W-1:0];
            CSR_BLOCK_SIZE: bs_in = csr_wdata[BLOCK_SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff <= LINE_WIDTH_RST;
         bs_ff <= BLOCK_SIZE_RST;
      end else begin
         lw_ff <= lw_in;
         bs_ff <= bs_in;
      end
   end

   always_comb begin
      if (lw_ff == '0) begin
         w_eff = WID_W'(1);
      end else if (32'(lw_ff) > MAX_WIDTH) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(lw_ff);
      end
      if (bs_ff == '0) begin
         bs_eff = BS_W'(1);
      end else if (32'(bs_ff) > MAX_BLOCK) begin
         bs_eff = BS_W'(MAX_BLOCK);
      end else begin
         bs_eff = BS_W'(bs_ff);
      end
      area = AREA_W'(bs_eff) * AREA_W'(bs_eff);
   end

   // reciprocal tables
   logic [POS_W:0] recip_bs_tab   [MAX_BLOCK+1];
   logic [SUM_W:0] recip_area_tab [MAX_BLOCK+1];

   assign recip_bs_tab[0]   = '0;
   assign recip_area_tab[0] = '0;
   for (genvar Div = 1; Div <= MAX_BLOCK; Div++) begin : g_recip
      localparam int unsigned RecipBs   = (2 ** POS_W) / Div;
      localparam int unsigned RecipArea = (2 ** SUM_W) / (Div * Div);
      assign recip_bs_tab[Div]   = (POS_W + 1)'(RecipBs);
      assign recip_area_tab[Div] = (SUM_W + 1)'(RecipArea);
   end

   // stage control
   logic [STAGES:1] vld_ff, vld_in, en;
   logic            accept;

   always_comb begin
      en[STAGES] = !vld_ff[STAGES] || rsp_tready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[1] = en[1] ? req_tvalid : vld_ff[1];
      for (int k = 2; k <= STAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = en[1];
   assign accept     = req_tvalid && req_tready;

   // position counters
   logic [POS_W-1:0] col_ff, col_in, pos0;
   logic [ROW_W-1:0] row_ff, row_in, row0;
   logic [WID_W-1:0] pos_nxt;
   logic [BS_W-1:0]  row_nxt;

   always_comb begin
      pos0 = req_tuser ? '0 : col_ff;
      row0 = req_tuser ? '0 : row_ff;
      if (WID_W'(pos0) >= w_eff) begin
         pos0 = '0;
      end
      if (BS_W'(row0) >= bs_eff) begin
         row0 = '0;
      end
      pos_nxt = WID_W'(pos0) + WID_W'(1);
      row_nxt = BS_W'(row0) + BS_W'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (pos_nxt >= w_eff) begin
            col_in = '0;
            row_in = (row_nxt >= bs_eff) ? '0 : ROW_W'(row_nxt);
         end else begin
            col_in = POS_W'(pos_nxt);
            row_in = row0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // color matrix, stages 1 to 3
   rycs_adv_type       csc_adv;
   logic [BYTE_W-1:0]  y3, cb3, cr3;

   assign csc_adv = '{s1: en[1], s2: en[2], s3: en[3]};

   rycs_csc u_csc (
      .clock     (clock),
      .adv       (csc_adv),
      .red       (req_tdata[BYTE_W-1:0]),
      .green     (req_tdata[2*BYTE_W-1:BYTE_W]),
      .blue      (req_tdata[3*BYTE_W-1:2*BYTE_W]),
      .luma      (y3),
      .cb        (cb3),
      .cr        (cr3)
   );

   // block column and offset
   logic [POS_W-1:0]   pos1_ff, pos2_ff, qest2_ff;
   logic [ROW_W-1:0]   row1_ff, row2_ff;
   logic [2*POS_W:0]   qprod;
   logic [POS_W+BS_W-1:0] qbs;
   logic [POS_W-1:0]   rem2, idx2;
   logic [ROW_W-1:0]   off2;
   logic               first2, last2;

   always_comb begin
      qprod = (2*POS_W + 1)'(pos1_ff) * (2*POS_W + 1)'(recip_bs_tab[bs_eff]);
      qbs   = (POS_W + BS_W)'(qest2_ff) * (POS_W + BS_W)'(bs_eff);
      rem2  = pos2_ff - POS_W'(qbs);
      idx2  = qest2_ff;
      if (32'(rem2) >= 32'(bs_eff)) begin
         rem2 = rem2 - POS_W'(bs_eff);
         idx2 = qest2_ff + POS_W'(1);
      end
      off2   = ROW_W'(rem2);
      first2 = (off2 == '0) && (row2_ff == '0);
      last2  = (32'(off2) == 32'(bs_eff) - 1) && (32'(row2_ff) == 32'(bs_eff) - 1);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pos1_ff <= pos0;
         row1_ff <= row0;
      end
      if (en[2]) begin
         qest2_ff <= qprod[2*POS_W-1:POS_W];
         pos2_ff  <= pos1_ff;
         row2_ff  <= row1_ff;
      end
   end

   // accumulator read-modify-write
   logic [2*SUM_W-1:0] acc_mem [MAX_WIDTH];
   logic [2*SUM_W-1:0] rd_data_ff, fwd_data_ff, acc_old, acc_new;
   logic               fwd_hit_ff, wr_en, rd_en;
   logic [POS_W-1:0]   idx3_ff, idx4_ff;
   logic               first3_ff, first4_ff;
   logic               last3_ff, last4_ff, last5_ff, last6_ff;
   logic [BYTE_W-1:0]  y4_ff, cb4_ff, cr4_ff, y5_ff, y6_ff;
   logic [SUM_W-1:0]   cb_new, cr_new;

   always_comb begin
      acc_old = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      if (first4_ff) begin
         cb_new = SUM_W'(cb4_ff);
         cr_new = SUM_W'(cr4_ff);
      end else begin
         cb_new = acc_old[SUM_W-1:0] + SUM_W'(cb4_ff);
         cr_new = acc_old[2*SUM_W-1:SUM_W] + SUM_W'(cr4_ff);
      end
      acc_new = {cr_new, cb_new};
   end

   assign rd_en = en[4] && vld_ff[3];
   assign wr_en = en[5] && vld_ff[4];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         acc_mem[idx4_ff] <= acc_new;
      end
      if (rd_en) begin
         rd_data_ff <= acc_mem[idx3_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         idx3_ff   <= idx2;
         first3_ff <= first2;
         last3_ff  <= last2;
      end
      if (en[4]) begin
         idx4_ff     <= idx3_ff;
         first4_ff   <= first3_ff;
         last4_ff    <= last3_ff;
         y4_ff       <= y3;
         cb4_ff      <= cb3;
         cr4_ff      <= cr3;
         fwd_hit_ff  <= wr_en && (idx4_ff == idx3_ff);
         fwd_data_ff <= acc_new;
      end
   end

   // block average
   logic [SUM_W-1:0]     cbs5_ff, crs5_ff, cbs6_ff, crs6_ff;
   logic [SUM_W-1:0]     cbq6_ff, crq6_ff, cb_rem, cr_rem, cb_avg, cr_avg;
   logic [2*SUM_W:0]     cb_prod, cr_prod;
   logic [SUM_W+AREA_W-1:0] cb_back, cr_back;

   always_comb begin
      cb_prod = (2*SUM_W + 1)'(cbs5_ff) * (2*SUM_W + 1)'(recip_area_tab[bs_eff]);
      cr_prod = (2*SUM_W + 1)'(crs5_ff) * (2*SUM_W + 1)'(recip_area_tab[bs_eff]);
      cb_back = (SUM_W + AREA_W)'(cbq6_ff) * (SUM_W + AREA_W)'(area);
      cr_back = (SUM_W + AREA_W)'(crq6_ff) * (SUM_W + AREA_W)'(area);
      cb_rem  = cbs6_ff - SUM_W'(cb_back);
      cr_rem  = crs6_ff - SUM_W'(cr_back);
      cb_avg  = (32'(cb_rem) >= 32'(area)) ? cbq6_ff + SUM_W'(1) : cbq6_ff;
      cr_avg  = (32'(cr_rem) >= 32'(area)) ? crq6_ff + SUM_W'(1) : crq6_ff;
   end

   logic [BYTE_W-1:0] luma_ff, blue_diff_ff, red_diff_ff;
   logic              chroma_valid_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         y5_ff    <= y4_ff;
         last5_ff <= last4_ff;
         cbs5_ff  <= cb_new;
         crs5_ff  <= cr_new;
      end
      if (en[6]) begin
         y6_ff    <= y5_ff;
         last6_ff <= last5_ff;
         cbs6_ff  <= cbs5_ff;
         crs6_ff  <= crs5_ff;
         cbq6_ff  <= cb_prod[2*SUM_W-1:SUM_W];
         crq6_ff  <= cr_prod[2*SUM_W-1:SUM_W];
      end
      if (en[7]) begin
         luma_ff         <= y6_ff;
         chroma_valid_ff <= last6_ff;
         blue_diff_ff    <= last6_ff ? cb_avg[BYTE_W-1:0] : '0;
         red_diff_ff     <= last6_ff ? cr_avg[BYTE_W-1:0] : '0;
      end
   end

   assign rsp_tdata  = {red_diff_ff, blue_diff_ff, luma_ff};
   assign rsp_tuser  = chroma_valid_ff;
   assign rsp_tvalid = vld_ff[STAGES];

   `RYCS_ASSERT(a_luma_range, clock, reset, vld_ff[3] |-> (y3 >= 8'd16 && y3 <= 8'd235), "luma outside studio range")
   `RYCS_ASSERT(a_chroma_range, clock, reset, vld_ff[3] |-> (cb3 >= 8'd16 && cb3 <= 8'd240 && cr3 >= 8'd16 && cr3 <= 8'd240), "chroma outside studio range")
   `RYCS_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_tvalid, "result pending after reset")

endmodule

`default_nettype wire

[tb/sv/ycbcr_subsample_checker.sv]
// Checker for the RGB to YCbCr subsampling core: watches the pixel, result and
// register ports, predicts luma and block-averaged chroma, and compares.
// Depends on rycs_pkg for port widths and register indexes.
`timescale 1ns / 1ps

module ycbcr_subsample_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [rycs_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tuser,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [rycs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               rsp_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [rycs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rycs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                 mismatch_count,
   output int                                 pending,
   output int                                 blocks_checked
);

   localparam int Q16_ONE   = 65536;
   localparam int LUMA_R    = 16829;
   localparam int LUMA_G    = 33039;
   localparam int LUMA_B    = 6416;
   localparam int CB_R      = 9714;
   localparam int CB_G      = 19070;
   localparam int CB_B      = 28784;
   localparam int CR_R      = 28784;
   localparam int CR_G      = 24103;
   localparam int CR_B      = 4681;
   localparam int unsigned WIDTH_CAP = 1024;
   localparam int unsigned BLOCK_CAP = 8;

   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] blue_diff;
      logic [7:0] red_diff;
   } ycc_result_type;

   logic [10:0]      line_width_q;
   logic [3:0]       block_size_q;
   int unsigned      cb_acc [WIDTH_CAP];
   int unsigned      cr_acc [WIDTH_CAP];
   int unsigned      col_pos;
   int unsigned      blk_row;
   ycc_result_type   expected_q [$];
   int               results_seen;

   function automatic logic [7:0] q16_saturate(input int v);
      int whole;
      if (v < 0) begin
         return 8'd0;
      end
      whole = v >>> 16;
      return (whole > 255) ? 8'd255 : 8'(whole);
   endfunction

   function automatic ycc_result_type convert_pixel(input logic frame_start,
                                                    input logic [7:0] red,
                                                    input logic [7:0] green,
                                                    input logic [7:0] blue);
      int unsigned w, bs, idx, off, area;
      int ri, gi, bi;
      logic [7:0] cb, cr;
      logic first, last;
      ycc_result_type res;
      w  = line_width_q;
      bs = block_size_q;
      if (bs == 0) bs = 1;
      if (bs > BLOCK_CAP) bs = BLOCK_CAP;
      if (w == 0) w = 1;
      if (w > WIDTH_CAP) w = WIDTH_CAP;
      if (frame_start) begin
         col_pos = 0;
         blk_row = 0;
      end
      if (col_pos >= w) col_pos = 0;
      if (blk_row >= bs) blk_row = 0;
      ri = red;
      gi = green;
      bi = blue;
      res.luma = q16_saturate(16 * Q16_ONE + LUMA_R * ri + LUMA_G * gi + LUMA_B * bi);
      cb = q16_saturate(128 * Q16_ONE - CB_R * ri - CB_G * gi + CB_B * bi);
      cr = q16_saturate(128 * Q16_ONE + CR_R * ri - CR_G * gi - CR_B * bi);
      idx   = (col_pos / bs) % WIDTH_CAP;
      off   = col_pos % bs;
      first = (off == 0) && (blk_row == 0);
      last  = (off == bs - 1) && (blk_row == bs - 1) && (col_pos - off + bs <= w);
      if (first) begin
         cb_acc[idx] = cb;
         cr_acc[idx] = cr;
      end else begin
         cb_acc[idx] += cb;
         cr_acc[idx] += cr;
      end
      res.chroma_valid = last;
      res.blue_diff    = 8'd0;
      res.red_diff     = 8'd0;
      if (last) begin
         area = bs * bs;
         res.blue_diff = 8'(cb_acc[idx] / area);
         res.red_diff  = 8'(cr_acc[idx] / area);
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         blk_row++;
         if (blk_row >= bs) blk_row = 0;
      end
      return res;
   endfunction

   initial begin
      mismatch_count = 0;
      pending        = 0;
      blocks_checked = 0;
      results_seen   = 0;
   end

   always @(posedge clock) begin
      ycc_result_type got, want, pred;
      if (reset) begin
         line_width_q = rycs_pkg::LINE_WIDTH_RST;
         block_size_q = rycs_pkg::BLOCK_SIZE_RST;
         for (int i = 0; i < WIDTH_CAP; i++) begin
            cb_acc[i] = 0;
            cr_acc[i] = 0;
         end
         col_pos = 0;
         blk_row = 0;
         expected_q.delete();
         pending <= 0;
      end else begin
         if (csr_we) begin
            case (rycs_pkg::csr_reg_type'(csr_index))
               rycs_pkg::CSR_LINE_WIDTH: line_width_q = csr_wdata[10:0];
               rycs_pkg::CSR_BLOCK_SIZE: block_size_q = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            pred       = convert_pixel(req_tuser, req_tdata[7:0],
                                       req_tdata[15:8], req_tdata[23:16]);
            expected_q = {expected_q, pred};
         end
         if (rsp_tvalid && rsp_tready) begin
            got.luma         = rsp_tdata[7:0];
            got.chroma_valid = rsp_tuser;
            got.blue_diff    = rsp_tdata[15:8];
            got.red_diff     = rsp_tdata[23:16];
            results_seen++;
            if (expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result %0d: Y=%0d valid=%0d Cb=%0d Cr=%0d",
                           results_seen, got.luma, got.chroma_valid,
                           got.blue_diff, got.red_diff);
            end else begin
               want = expected_q.pop_front();
               if (want.chroma_valid) blocks_checked++;
               if (got.luma !== want.luma || got.chroma_valid !== want.chroma_valid ||
                   got.blue_diff !== want.blue_diff || got.red_diff !== want.red_diff) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch on result %0d: expected Y=%0d valid=%0d Cb=%0d Cr=%0d, got Y=%0d valid=%0d Cb=%0d Cr=%0d",
                              results_seen, want.luma, want.chroma_valid, want.blue_diff,
                              want.red_diff, got.luma, got.chroma_valid, got.blue_diff,
                              got.red_diff);
               end
            end
         end
         pending <= expected_q.size();
      end
   end

endmodule

[tb/sv/tb_rgb_to_ycbcr_subsample_core.sv]
// Testbench top for rgb_to_ycbcr_subsample_core: drives pixels and register
// writes under varying backpressure and reports the verdict.
// Depends on rycs_pkg, the core and ycbcr_subsample_checker.
`timescale 1ns / 1ps

module tb_rgb_to_ycbcr_subsample_core;

   typedef enum int {
      MODE_FREE,
      MODE_SRC_IDLE,
      MODE_SNK_STALL,
      MODE_BOTH
   } idle_mode_type;

   localparam int NUM_PHASES   = 9;
   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 400;

   localparam int unsigned PH_WIDTH [NUM_PHASES] = '{4, 8, 6, 0, 2047, 1024, 24, 12, 16};
   localparam int unsigned PH_BLOCK [NUM_PHASES] = '{2, 8, 4, 0, 2047, 1, 3, 4, 8};
   localparam int unsigned PH_ITEMS [NUM_PHASES] = '{60, 70, 50, 40, 60, 60, 80, 60, 40};
   localparam idle_mode_type PH_MODE [NUM_PHASES] = '{MODE_FREE, MODE_SRC_IDLE,
      MODE_SNK_STALL, MODE_BOTH, MODE_FREE, MODE_SRC_IDLE, MODE_SNK_STALL, MODE_BOTH,
      MODE_FREE};

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic [rycs_pkg::REQ_DATA_W-1:0]    req_tdata = '0;
   logic                               req_tuser = 1'b0;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [rycs_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                               rsp_tuser;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic                               csr_we = 1'b0;
   logic [rycs_pkg::CSR_INDEX_W-1:0]   csr_index = '0;
   logic [rycs_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   int            mismatch_count, pending, blocks_checked;
   idle_mode_type mode = MODE_FREE;
   logic          hold_trigger = 1'b0;
   logic          hold_taken = 1'b0;
   int            hold_left = 0;
   int            cycle_count = 0;
   int            pixels_sent = 0;

   rgb_to_ycbcr_subsample_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   ycbcr_subsample_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending        (pending),
      .blocks_checked (blocks_checked)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: hold off once for a long stretch, otherwise stall per mode
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_trigger && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         case (mode)
            MODE_SNK_STALL: rsp_tready <= ($urandom_range(99) >= 70);
            MODE_BOTH:      rsp_tready <= ($urandom_range(99) >= 10);
            default:        rsp_tready <= 1'b1;
         endcase
      end
   end

   task automatic send_pixel(input logic fs, input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue);
      int unsigned idle_pct;
      case (mode)
         MODE_SRC_IDLE: idle_pct = 70;
         MODE_BOTH:     idle_pct = 10;
         default:       idle_pct = 0;
      endcase
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fs;
      req_tdata  <= {blue, green, red};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input rycs_pkg::csr_reg_type idx,
                            input logic [rycs_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15) return 8'd0;
      if (roll < 30) return 8'd255;
      return 8'($urandom_range(255));
   endfunction

   initial begin
      logic fs;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration: primaries and extremes
      send_pixel(1'b1, 8'd0, 8'd0, 8'd0);
      send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
      send_pixel(1'b0, 8'd255, 8'd0, 8'd0);
      send_pixel(1'b0, 8'd0, 8'd255, 8'd0);
      send_pixel(1'b0, 8'd0, 8'd0, 8'd255);
      send_pixel(1'b0, 8'd128, 8'd128, 8'd128);
      wait_drained();

      // 2x2 blocks on a two-pixel line
      write_csr(rycs_pkg::CSR_LINE_WIDTH, 11'd2);
      write_csr(rycs_pkg::CSR_BLOCK_SIZE, 11'd2);
      send_pixel(1'b1, 8'd0, 8'd0, 8'd0);
      send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
      send_pixel(1'b0, 8'd255, 8'd0, 8'd0);
      send_pixel(1'b0, 8'd0, 8'd255, 8'd0);
      send_pixel(1'b0, 8'd0, 8'd0, 8'd255);
      send_pixel(1'b0, 8'd255, 8'd255, 8'd0);
      send_pixel(1'b0, 8'd0, 8'd255, 8'd255);
      send_pixel(1'b0, 8'd255, 8'd0, 8'd255);
      send_pixel(1'b0, 8'd10, 8'd20, 8'd30);
      send_pixel(1'b1, 8'd40, 8'd50, 8'd60);
      send_pixel(1'b0, 8'd70, 8'd80, 8'd90);
      send_pixel(1'b0, 8'd170, 8'd85, 8'd1);
      send_pixel(1'b0, 8'd254, 8'd1, 8'd127);
      send_pixel(1'b1, 8'd255, 8'd0, 8'd0);
      send_pixel(1'b0, 8'd255, 8'd0, 8'd0);
      send_pixel(1'b0, 8'd255, 8'd0, 8'd0);
      send_pixel(1'b0, 8'd255, 8'd0, 8'd0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         write_csr(rycs_pkg::CSR_LINE_WIDTH, rycs_pkg::CSR_DATA_W'(PH_WIDTH[p]));
         write_csr(rycs_pkg::CSR_BLOCK_SIZE, rycs_pkg::CSR_DATA_W'(PH_BLOCK[p]));
         mode = PH_MODE[p];
         if (p == 0) hold_trigger = 1'b1;
         for (int n = 0; n < PH_ITEMS[p]; n++) begin
            fs = (n == 0) || ($urandom_range(99) < 3);
            send_pixel(fs, pick_byte(), pick_byte(), pick_byte());
         end
      end
      wait_drained();
      repeat (20) @(posedge clock);

      $display("Sent %0d pixels over %0d register settings; %0d chroma blocks compared.",
               pixels_sent, NUM_PHASES + 2, blocks_checked);
      if (mismatch_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
